[src/cvte_pkg.sv]
// ----------------------------------------------------------------------------
// cvte_pkg: shared types and constants for the compacting value table
// Command and result words, operation codes, sequencer states and the
// compare flags that pass from the compare unit to the sequencer.
// ----------------------------------------------------------------------------
package cvte_pkg;

    // Default table shape
    localparam int DEF_TABLE_DEPTH = 32;
    localparam int DEF_VALUE_WIDTH = 16;

    // Fixed field widths of the command and result words
    localparam int FUNC_W  = 3;
    localparam int FIELD_W = 16;
    localparam int POS_W   = 5;
    localparam int INDEX_W = 5;

    // Operation codes
    typedef enum logic [FUNC_W-1:0] {
        FN_APPEND    = 3'd0,
        FN_DELETE    = 3'd1,
        FN_SEARCH    = 3'd2,
        FN_MODIFY    = 3'd3,
        FN_OVERWRITE = 3'd4
    } func_e_t;

    // Command word
    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [FIELD_W-1:0] key;
        logic [FIELD_W-1:0] new_value;
        logic [POS_W-1:0]   position;
    } cmd_t;

    // Result word
    typedef struct packed {
        logic               ok;
        logic [INDEX_W-1:0] index;
    } result_t;

    // Compare unit flags on the slot just read
    typedef struct packed {
        logic match;
        logic empty;
    } flags_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_APP_LAST,
        ST_OVW_CHK,
        ST_SCAN,
        ST_SHIFT,
        ST_CLR_LAST
    } state_t;

endpackage

[src/compacting_value_table_engine.sv]
// ----------------------------------------------------------------------------
// compacting_value_table_engine: unsorted value table with compaction
// Append, delete with compaction, search, modify-all and overwrite on a
// table of value slots where zero marks an empty slot.
//
//  channel  | ports                | strobe / accept
//  ---------+----------------------+-------------------------------------
//  command  | cmd (cmd_t)          | start high while busy low
//  result   | result (result_t)    | done high for one cycle
//
//  After reset the table is zeroed, one slot a cycle, with busy held high.
//  Each command word then takes one slot per cycle on the single RAM read
//  port and shared comparator. The result word is shown on done for one
//  cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module compacting_value_table_engine
    import cvte_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  cmd_t    cmd,
    output logic    busy,
    output logic    done,
    output result_t result
);

    localparam int AW = $clog2(TABLE_DEPTH);

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [VALUE_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [VALUE_WIDTH-1:0] ram_rdata;
    logic [VALUE_WIDTH-1:0] key_val;
    flags_t                 flags;

    // Slot store
    cvte_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared comparator
    cvte_cmp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cmp (
        .slot    (ram_rdata),
        .key_val (key_val),
        .flags   (flags)
    );

    // Sequencer
    cvte_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .key_val   (key_val),
        .flags     (flags)
    );

endmodule

[src/cvte_ram.sv]
// ----------------------------------------------------------------------------
// cvte_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module cvte_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/cvte_cmp.sv]
// ----------------------------------------------------------------------------
// cvte_cmp: slot compare unit
// Compares the slot word read from the table against the key and zero.
// ----------------------------------------------------------------------------
module cvte_cmp
    import cvte_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic [VALUE_WIDTH-1:0] slot,
    input  logic [VALUE_WIDTH-1:0] key_val,
    output flags_t                 flags
);

    // Equality with the key, and empty-slot detect
    always_comb
    begin
        flags.match = (slot == key_val);
        flags.empty = (slot == '0);
    end

endmodule

[src/cvte_ctrl.sv]
// ----------------------------------------------------------------------------
// cvte_ctrl: table sequencer
// Walks the table one slot per cycle through the RAM read port, acts on
// the compare flags, shifts slots down for delete and clears the table
// after reset.
// ----------------------------------------------------------------------------
module cvte_ctrl
    import cvte_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
    localparam int AW         = $clog2(TABLE_DEPTH)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  cmd_t                   cmd,
    output logic                   busy,
    output logic                   done,
    output result_t                result,
    output logic                   ram_we,
    output logic [AW-1:0]          ram_waddr,
    output logic [VALUE_WIDTH-1:0] ram_wdata,
    output logic [AW-1:0]          ram_raddr,
    input  logic [VALUE_WIDTH-1:0] ram_rdata,
    output logic [VALUE_WIDTH-1:0] key_val,
    input  flags_t                 flags
);

    localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_DEPTH - 1);
    localparam logic [AW:0]   END_ADDR  = (AW + 1)'(TABLE_DEPTH);

    state_t                 state_reg, state_next;
    func_e_t                op_reg, op_next;
    logic [VALUE_WIDTH-1:0] key_reg, key_next;
    logic [VALUE_WIDTH-1:0] nv_reg, nv_next;
    logic [AW-1:0]          pos_reg, pos_next;
    logic [AW:0]            addr_reg, addr_next;
    logic [AW-1:0]          chk_reg, chk_next;
    logic                   ok_reg, ok_next;
    logic                   done_reg, done_next;
    result_t                res_reg, res_next;

    logic                   chk_last;
    logic                   pos_in_range;
    logic [AW-1:0]          scan_raddr;
    logic                   fin;
    logic                   fin_ok;
    logic [INDEX_W-1:0]     fin_idx;

    // chk_reg is the slot whose word sits on ram_rdata
    assign chk_last     = (chk_reg == LAST_SLOT);
    assign pos_in_range = (int'(cmd.position) < TABLE_DEPTH);
    assign scan_raddr   = (addr_reg < END_ADDR) ? addr_reg[AW-1:0] : '0;

    assign key_val = key_reg;
    assign busy    = (state_reg != ST_IDLE);
    assign done    = done_reg;
    assign result  = res_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (chk_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    case (func_e_t'(cmd.func))
                        FN_APPEND:
                        begin
                            state_next = ST_APP_LAST;
                        end
                        FN_DELETE, FN_SEARCH, FN_MODIFY:
                        begin
                            state_next = ST_SCAN;
                        end
                        FN_OVERWRITE:
                        begin
                            state_next = pos_in_range ? ST_OVW_CHK : ST_IDLE;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_APP_LAST:
            begin
                state_next = flags.empty ? ST_SCAN : ST_IDLE;
            end
            ST_OVW_CHK:
            begin
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                case (op_reg)
                    FN_APPEND:
                    begin
                        if (flags.empty || chk_last)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    FN_SEARCH, FN_MODIFY:
                    begin
                        if ((op_reg == FN_SEARCH && flags.match) || chk_last)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    FN_DELETE:
                    begin
                        if (flags.match)
                        begin
                            state_next = chk_last ? ST_CLR_LAST : ST_SHIFT;
                        end
                        else if (chk_last)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_SHIFT:
            begin
                if (chk_last)
                begin
                    state_next = ST_CLR_LAST;
                end
            end
            ST_CLR_LAST:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs: RAM control, working registers and completion
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = chk_reg;
        ram_wdata = nv_reg;
        ram_raddr = scan_raddr;
        op_next   = op_reg;
        key_next  = key_reg;
        nv_next   = nv_reg;
        pos_next  = pos_reg;
        addr_next = addr_reg;
        chk_next  = chk_reg;
        ok_next   = ok_reg;
        fin       = 1'b0;
        fin_ok    = 1'b0;
        fin_idx   = '0;

        unique case (state_reg)
            // Zero every slot after reset
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                chk_next  = chk_reg + AW'(1);
            end
            // Take a command word, issue the first read
            ST_IDLE:
            begin
                ram_raddr = '0;
                if (start)
                begin
                    op_next   = func_e_t'(cmd.func);
                    key_next  = VALUE_WIDTH'(cmd.key);
                    nv_next   = VALUE_WIDTH'(cmd.new_value);
                    pos_next  = AW'(cmd.position);
                    ok_next   = 1'b0;
                    chk_next  = '0;
                    addr_next = (AW + 1)'(1);
                    case (func_e_t'(cmd.func))
                        FN_APPEND:
                        begin
                            ram_raddr = LAST_SLOT;
                        end
                        FN_DELETE, FN_SEARCH, FN_MODIFY:
                        begin
                            ram_raddr = '0;
                        end
                        FN_OVERWRITE:
                        begin
                            if (pos_in_range)
                            begin
                                ram_raddr = AW'(cmd.position);
                            end
                            else
                            begin
                                fin = 1'b1;
                            end
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            // Append: last slot must be empty, then scan from slot 0
            ST_APP_LAST:
            begin
                ram_raddr = '0;
                chk_next  = '0;
                addr_next = (AW + 1)'(1);
                if (!flags.empty)
                begin
                    fin = 1'b1;
                end
            end
            // Overwrite only an occupied slot
            ST_OVW_CHK:
            begin
                fin = 1'b1;
                if (!flags.empty)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pos_reg;
                    fin_ok    = 1'b1;
                end
            end
            // One slot checked per cycle, next read already issued
            ST_SCAN:
            begin
                chk_next  = addr_reg[AW-1:0];
                addr_next = addr_reg + (AW + 1)'(1);
                case (op_reg)
                    FN_APPEND:
                    begin
                        if (flags.empty)
                        begin
                            ram_we = 1'b1;
                            fin    = 1'b1;
                            fin_ok = 1'b1;
                        end
                        else if (chk_last)
                        begin
                            fin = 1'b1;
                        end
                    end
                    FN_SEARCH:
                    begin
                        if (flags.match)
                        begin
                            fin     = 1'b1;
                            fin_ok  = 1'b1;
                            fin_idx = INDEX_W'(chk_reg);
                        end
                        else if (chk_last)
                        begin
                            fin = 1'b1;
                        end
                    end
                    FN_MODIFY:
                    begin
                        if (flags.match)
                        begin
                            ram_we  = 1'b1;
                            ok_next = 1'b1;
                        end
                        if (chk_last)
                        begin
                            fin    = 1'b1;
                            fin_ok = ok_reg | flags.match;
                        end
                    end
                    FN_DELETE:
                    begin
                        if (!flags.match && chk_last)
                        begin
                            fin = 1'b1;
                        end
                    end
                    default:
                    begin
                        fin = 1'b1;
                    end
                endcase
            end
            // Delete: move each later slot down by one
            ST_SHIFT:
            begin
                ram_we    = 1'b1;
                ram_waddr = chk_reg - AW'(1);
                ram_wdata = ram_rdata;
                chk_next  = addr_reg[AW-1:0];
                addr_next = addr_reg + (AW + 1)'(1);
            end
            // Delete: empty the last slot
            ST_CLR_LAST:
            begin
                ram_we    = 1'b1;
                ram_waddr = LAST_SLOT;
                ram_wdata = '0;
                fin       = 1'b1;
                fin_ok    = 1'b1;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase

        done_next = fin;
        res_next  = res_reg;
        if (fin)
        begin
            res_next.ok    = fin_ok;
            res_next.index = fin_idx;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            chk_reg   <= '0;
            addr_reg  <= '0;
            ok_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            chk_reg   <= chk_next;
            addr_reg  <= addr_next;
            ok_reg    <= ok_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        key_reg <= key_next;
        nv_reg  <= nv_next;
        pos_reg <= pos_next;
        res_reg <= res_next;
    end

endmodule
